// ===== rtl/core/sspc_pkg.sv =====
`timescale 1ns / 1ps

package sspc_pkg;

    // converter and calibration sizing
    localparam int SampleBits   = 10;
    localparam int CalibSamples = 30;
    localparam int RatioBits    = 16;
    localparam int TickBits     = RatioBits + 1;
    localparam int CountBits    = $clog2(CalibSamples + 1);
    localparam int SumBits      = $clog2(CalibSamples * (2**SampleBits - 1) + 1);

    // percentage math
    localparam int PctBits      = 11;
    localparam int PctLimit     = 1000;
    localparam int PctScale     = 100;
    localparam int DivBits      = $clog2((2**SampleBits - 1) * PctScale + 1);
    localparam int DivCntBits   = $clog2(DivBits + 1);

    // reset values of the references, the tick counter and the ratio
    localparam int WaterReset   = 353;
    localparam int DryReset     = 1022;
    localparam int TickReset    = 65535;
    localparam int RatioReset   = 1;

    // register port
    localparam int AddrBits     = 3;
    localparam int DataBits     = 32;
    localparam logic [AddrBits-3:0] RegTicksPerMeasure = '0;

    typedef enum logic [1:0] {
        REQ_TICK  = 2'd0,
        REQ_WATER = 2'd1,
        REQ_DRY   = 2'd2,
        REQ_RESET = 2'd3
    } req_t;

    typedef struct packed {
        req_t                  req_type;
        logic [SampleBits-1:0] adc_sample;
    } req_item_t;

    typedef struct packed {
        logic signed [PctBits-1:0] percent_moisture;
        logic                      calib_invalid;
        logic                      calib_done;
        logic                      measured;
    } rsp_item_t;

endpackage

// ===== rtl/core/sensor_sampler_two_point_calibration.sv =====
// each accepted item runs to its result before the next is taken; a calibration
//   step that completes the sample set first averages the new reference, and equal
//   references skip the percentage division; both divisions use the bit-serial
//   divider that resolves one quotient bit per cycle
// reset: rst_n clears all state at once to the calibration defaults; no sweep
`timescale 1ns / 1ps

module sensor_sampler_two_point_calibration
    import sspc_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,

    // register port
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [AddrBits-1:0] paddr,
    input  logic [DataBits-1:0] pwdata,
    output logic [DataBits-1:0] prdata,
    output logic                pready,

    // request items
    input  logic                req_valid,
    output logic                req_ready,
    input  req_item_t           req_data,

    // result items
    output logic                rsp_valid,
    input  logic                rsp_ready,
    output rsp_item_t           rsp_data
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_AVG_START,
        ST_AVG_WAIT,
        ST_PCT_LOAD,
        ST_PCT_WAIT,
        ST_OUT
    } state_t;

    state_t state_reg, state_next;

    // configuration
    logic [RatioBits-1:0]  ratio_reg, ratio_next;

    // sampler and calibration state
    logic [TickBits-1:0]   tick_count_reg, tick_count_next;
    logic [SampleBits-1:0] last_reg, last_next;
    logic [SampleBits-1:0] water_reg, water_next;
    logic [SampleBits-1:0] dry_reg, dry_next;
    logic [CountBits-1:0]  count_reg, count_next;
    logic [SumBits-1:0]    sum_reg, sum_next;

    // per item flags carried to the result
    logic                  is_dry_reg, is_dry_next;
    logic                  done_flag_reg, done_flag_next;
    logic                  measured_reg, measured_next;
    logic                  invalid_reg, invalid_next;
    logic                  neg_reg, neg_next;

    // result holding register
    logic                  rsp_valid_reg, rsp_valid_next;
    rsp_item_t             rsp_reg, rsp_next;

    // helpers
    logic                  req_fire;
    logic                  reg_hit;
    logic                  avg_pending;
    logic [TickBits-1:0]   tick_inc;
    logic [CountBits-1:0]  count_inc;
    logic [SampleBits:0]   span;
    logic [SampleBits:0]   span_neg;
    logic [SampleBits:0]   dev;
    logic [SampleBits:0]   dev_neg;
    logic [SampleBits-1:0] span_mag;
    logic [SampleBits-1:0] dev_mag;
    logic [DivBits-1:0]    pct_dividend;
    logic [PctBits-1:0]    pct_mag;
    logic [PctBits-1:0]    pct_val;

    // shared divider: reference average and percentage
    logic                  div_start;
    logic [DivBits-1:0]    div_dividend;
    logic [SampleBits-1:0] div_divisor;
    logic [DivBits-1:0]    div_quotient;
    logic                  div_done;

    sspc_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .quotient (div_quotient),
        .done     (div_done)
    );

    // register port, always ready; writes belong between items
    assign pready  = 1'b1;
    assign reg_hit = (paddr[AddrBits-1:2] == RegTicksPerMeasure);
    assign prdata  = reg_hit ? DataBits'(ratio_reg) : '0;

    assign req_ready = (state_reg == ST_IDLE);
    assign req_fire  = req_valid && req_ready;
    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_reg;

    // signed span and deviation from the dry point, then magnitudes
    assign span     = {1'b0, dry_reg} - {1'b0, water_reg};
    assign span_neg = -span;
    assign dev      = {1'b0, dry_reg} - {1'b0, last_reg};
    assign dev_neg  = -dev;
    assign span_mag = span[SampleBits] ? span_neg[SampleBits-1:0] : span[SampleBits-1:0];
    assign dev_mag  = dev[SampleBits] ? dev_neg[SampleBits-1:0] : dev[SampleBits-1:0];

    // constant scale by 100, shifts and adds after synthesis
    assign pct_dividend = DivBits'(dev_mag * PctScale);

    // saturate the magnitude, then restore the sign (truncation toward zero)
    assign pct_mag = (div_quotient > DivBits'(PctLimit)) ? PctBits'(PctLimit)
                                                          : div_quotient[PctBits-1:0];
    assign pct_val = neg_reg ? -pct_mag : pct_mag;

    assign div_start    = (state_reg == ST_AVG_START) ||
                          ((state_reg == ST_PCT_LOAD) && (span != '0));
    assign div_dividend = (state_reg == ST_AVG_START) ? DivBits'(sum_reg) : pct_dividend;
    assign div_divisor  = (state_reg == ST_AVG_START) ? SampleBits'(CalibSamples)
                                                       : span_mag;

    assign tick_inc  = tick_count_reg + 1'b1;
    assign count_inc = count_reg + 1'b1;

    always_comb
    begin
        state_next      = state_reg;
        ratio_next      = ratio_reg;
        tick_count_next = tick_count_reg;
        last_next       = last_reg;
        water_next      = water_reg;
        dry_next        = dry_reg;
        count_next      = count_reg;
        sum_next        = sum_reg;
        is_dry_next     = is_dry_reg;
        done_flag_next  = done_flag_reg;
        measured_next   = measured_reg;
        invalid_next    = invalid_reg;
        neg_next        = neg_reg;
        rsp_next        = rsp_reg;
        rsp_valid_next  = rsp_valid_reg && !rsp_ready;
        avg_pending     = 1'b0;

        if (psel && penable && pwrite && reg_hit)
        begin
            ratio_next = pwdata[RatioBits-1:0];
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (req_fire)
                begin
                    measured_next  = 1'b0;
                    done_flag_next = 1'b0;
                    case (req_data.req_type)
                        REQ_TICK:
                        begin
                            // ratio of zero or not above the incremented count: measure now
                            if (tick_inc < {1'b0, ratio_reg})
                            begin
                                tick_count_next = tick_inc;
                            end
                            else
                            begin
                                tick_count_next = '0;
                                last_next       = req_data.adc_sample;
                                measured_next   = 1'b1;
                            end
                        end
                        REQ_WATER, REQ_DRY:
                        begin
                            is_dry_next = (req_data.req_type == REQ_DRY);
                            // a full set ignores further steps but reports done
                            if (count_reg >= CountBits'(CalibSamples))
                            begin
                                done_flag_next = 1'b1;
                            end
                            else
                            begin
                                sum_next   = sum_reg + SumBits'(last_reg);
                                count_next = count_inc;
                                if (count_inc == CountBits'(CalibSamples))
                                begin
                                    done_flag_next = 1'b1;
                                    avg_pending    = 1'b1;
                                end
                            end
                        end
                        REQ_RESET:
                        begin
                            count_next = '0;
                            sum_next   = '0;
                        end
                        default:
                        begin
                        end
                    endcase
                    state_next = avg_pending ? ST_AVG_START : ST_PCT_LOAD;
                end
            end
            ST_AVG_START:
            begin
                state_next = ST_AVG_WAIT;
            end
            ST_AVG_WAIT:
            begin
                if (div_done)
                begin
                    if (is_dry_reg)
                    begin
                        dry_next = div_quotient[SampleBits-1:0];
                    end
                    else
                    begin
                        water_next = div_quotient[SampleBits-1:0];
                    end
                    state_next = ST_PCT_LOAD;
                end
            end
            ST_PCT_LOAD:
            begin
                if (span == '0)
                begin
                    invalid_next = 1'b1;
                    state_next   = ST_OUT;
                end
                else
                begin
                    invalid_next = 1'b0;
                    neg_next     = span[SampleBits] ^ dev[SampleBits];
                    state_next   = ST_PCT_WAIT;
                end
            end
            ST_PCT_WAIT:
            begin
                if (div_done)
                begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                // hand over once the holding register is free
                if (!rsp_valid_reg || rsp_ready)
                begin
                    rsp_next.percent_moisture = invalid_reg ? '1 : pct_val;
                    rsp_next.calib_invalid    = invalid_reg;
                    rsp_next.calib_done       = done_flag_reg;
                    rsp_next.measured         = measured_reg;
                    rsp_valid_next            = 1'b1;
                    state_next                = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            ratio_reg      <= RatioBits'(RatioReset);
            tick_count_reg <= TickBits'(TickReset);
            last_reg       <= '0;
            water_reg      <= SampleBits'(WaterReset);
            dry_reg        <= SampleBits'(DryReset);
            count_reg      <= '0;
            sum_reg        <= '0;
            is_dry_reg     <= 1'b0;
            done_flag_reg  <= 1'b0;
            measured_reg   <= 1'b0;
            invalid_reg    <= 1'b0;
            neg_reg        <= 1'b0;
            rsp_valid_reg  <= 1'b0;
            rsp_reg        <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            ratio_reg      <= ratio_next;
            tick_count_reg <= tick_count_next;
            last_reg       <= last_next;
            water_reg      <= water_next;
            dry_reg        <= dry_next;
            count_reg      <= count_next;
            sum_reg        <= sum_next;
            is_dry_reg     <= is_dry_next;
            done_flag_reg  <= done_flag_next;
            measured_reg   <= measured_next;
            invalid_reg    <= invalid_next;
            neg_reg        <= neg_next;
            rsp_valid_reg  <= rsp_valid_next;
            rsp_reg        <= rsp_next;
        end
    end

endmodule

// ===== rtl/core/sspc_div.sv =====
`timescale 1ns / 1ps

module sspc_div
    import sspc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [DivBits-1:0]    dividend,
    input  logic [SampleBits-1:0] divisor,
    output logic [DivBits-1:0]    quotient,
    output logic                  done
);

    // restoring divider, one quotient bit per cycle
    logic [SampleBits-1:0] rem_reg, rem_next;
    logic [DivBits-1:0]    quo_reg, quo_next;
    logic [SampleBits-1:0] dsr_reg, dsr_next;
    logic [DivCntBits-1:0] cnt_reg, cnt_next;
    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [SampleBits:0]   rem_shift;
    logic [SampleBits+1:0] diff;
    logic                  fits;

    always_comb
    begin
        rem_shift = {rem_reg, quo_reg[DivBits-1]};
        diff      = {1'b0, rem_shift} - {2'b00, dsr_reg};
        fits      = !diff[SampleBits+1];

        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dsr_next  = dsr_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;

        if (start)
        begin
            rem_next  = '0;
            quo_next  = dividend;
            dsr_next  = divisor;
            cnt_next  = DivCntBits'(DivBits);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? diff[SampleBits-1:0] : rem_shift[SampleBits-1:0];
            quo_next = {quo_reg[DivBits-2:0], fits};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == DivCntBits'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg  <= '0;
            quo_reg  <= '0;
            dsr_reg  <= '0;
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            rem_reg  <= rem_next;
            quo_reg  <= quo_next;
            dsr_reg  <= dsr_next;
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    assign quotient = quo_reg;
    assign done     = done_reg;

endmodule

// ===== rtl/core/sspc_chk.sv =====
`timescale 1ns / 1ps

module sspc_chk
    import sspc_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic                psel,
    input logic                penable,
    input logic                pwrite,
    input logic [AddrBits-1:0] paddr,
    input logic [DataBits-1:0] pwdata,
    input logic [DataBits-1:0] prdata,
    input logic                pready,
    input logic                req_valid,
    input logic                req_ready,
    input req_item_t           req_data,
    input logic                rsp_valid,
    input logic                rsp_ready,
    input rsp_item_t           rsp_data
);

    localparam logic signed [PctBits-1:0] PctMax = PctBits'(PctLimit);
    localparam logic signed [PctBits-1:0] PctMin = -PctMax;

    // a held result keeps its value
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
        else $error("result changed while stalled");

    // one item in flight at a time
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("second item taken while busy");

    // equal references report minus one
    a_invalid_value: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_data.calib_invalid |-> rsp_data.percent_moisture == '1)
        else $error("invalid result without minus one");

    // a tick never completes a calibration and a step never measures
    a_flags_apart: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> !(rsp_data.calib_done && rsp_data.measured))
        else $error("measured and calib_done both set");

    // saturation limits
    a_pct_range: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (rsp_data.percent_moisture <= PctMax) &&
                      (rsp_data.percent_moisture >= PctMin))
        else $error("percentage out of range");

endmodule

bind sensor_sampler_two_point_calibration sspc_chk u_sspc_chk (.*);
